[hdl/shortest_edge_interval_estimator_top_assert.svh]
// Assertion macros for the grid step estimator.
`ifndef SHORTEST_EDGE_INTERVAL_ESTIMATOR_TOP_ASSERT_SVH
`define SHORTEST_EDGE_INTERVAL_ESTIMATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEIE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/seie_pkg.sv]
`default_nettype none

package seie_pkg;

	localparam int SUM_W = 40;
	localparam int CNT_W = 16;
	localparam int THR_W = 35;
	localparam int PC_W = 4;
	localparam int DIV_N_W = 7;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [31:0] STEP_MIN = 32'h0005_0000;
	localparam logic [31:0] WEND_RESET = 32'hFFFF_FFFF;
	localparam logic [DIV_N_W-1:0] DIV_BASE = 7'd56;
	localparam logic [2:0] MULT_LIMIT = 3'd4;

	localparam logic REG_ZOOM = 1'b0;
	localparam logic REG_WEND = 1'b1;

	localparam logic [PC_W-1:0] S_IDLE = 4'd0;
	localparam logic [PC_W-1:0] S_SKIP = 4'd1;
	localparam logic [PC_W-1:0] S_CH = 4'd2;
	localparam logic [PC_W-1:0] S_CMP = 4'd3;
	localparam logic [PC_W-1:0] S_MUL = 4'd4;
	localparam logic [PC_W-1:0] S_ACC = 4'd5;
	localparam logic [PC_W-1:0] S_NEXT = 4'd6;
	localparam logic [PC_W-1:0] S_FIN = 4'd7;
	localparam logic [PC_W-1:0] S_DIVI = 4'd8;
	localparam logic [PC_W-1:0] S_DIV = 4'd9;
	localparam logic [PC_W-1:0] S_OUT = 4'd10;
	localparam logic [PC_W-1:0] S_LAST = S_OUT;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SKIP,
		OP_EDGE,
		OP_CMP,
		OP_MUL,
		OP_ACC,
		OP_NEXT,
		OP_DIVI,
		OP_DIV,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_NO_IN,
		C_SKIP,
		C_NO_DELTA,
		C_NOT_MULT,
		C_MUL_MORE,
		C_MORE_CH,
		C_NOT_LAST,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Microprogram: when the condition holds the sequencer jumps to the target,
	// otherwise it steps on, wrapping from the last step back to idle.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] step);
		ctrl_t w;
		unique case (step)
			S_IDLE: w = '{OP_LOAD, C_NO_IN, S_IDLE};
			S_SKIP: w = '{OP_SKIP, C_SKIP, S_FIN};
			S_CH: w = '{OP_EDGE, C_NO_DELTA, S_NEXT};
			S_CMP: w = '{OP_CMP, C_NOT_MULT, S_NEXT};
			S_MUL: w = '{OP_MUL, C_MUL_MORE, S_MUL};
			S_ACC: w = '{OP_ACC, C_NEVER, S_IDLE};
			S_NEXT: w = '{OP_NEXT, C_MORE_CH, S_CH};
			S_FIN: w = '{OP_NONE, C_NOT_LAST, S_IDLE};
			S_DIVI: w = '{OP_DIVI, C_NEVER, S_IDLE};
			S_DIV: w = '{OP_DIV, C_DIV_MORE, S_DIV};
			S_OUT: w = '{OP_OUT, C_OUT_BUSY, S_OUT};
			default: w = '{OP_NONE, C_NEVER, S_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[hdl/shortest_edge_interval_estimator_top.sv]
// Grid step estimator for a logic analyzer view.
// The input stream carries one level-change word per event: tdata holds the
// new levels, the prior levels and the event time, and tlast marks the final
// event of a capture. Only a final event produces an output word: tdata is
// the Q16.16 grid step and tuser says whether any edge interval was found.
// Zoom and the window end are set over the APB port; the user must do so only
// while the block is idle, as the block itself does not enforce it. A small
// microprogram walks the channels one by one against the shared shortest
// interval. An event at or past the window end, or once the shortest interval
// is at or below the zoom threshold, is ignored; for each measured interval
// the multiple of the shortest is found by repeated addition. A final event
// then takes a setup step, a bit-serial divider and a step to post the word.
// The input is taken only when the sequencer is back at its idle step.
// The output word sits in a register; the next event is processed while it
// waits, and a later final event holds at the output step until it is taken.
// Reset clears the sequencer, the edge and interval state and the output
// valid, and sets zoom to 0 and the window end to all ones.
`default_nettype none

module shortest_edge_interval_estimator_top #(
	parameter int TIME_BITS = 32,
	parameter int CHANNELS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// new_levels, prior_levels, event_time, then zero padding
	input wire logic [((2*CHANNELS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	// grid_step
	output logic [31:0] m_tdata,
	// interval_found
	output logic m_tuser,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	import seie_pkg::*;

	`include "shortest_edge_interval_estimator_top_assert.svh"

	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WB = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int CW = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
	localparam int AW = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;
	localparam int MW = TIME_BITS + 3;
	localparam logic [CHW-1:0] CH_LAST = CHW'(CHANNELS - 1);

	logic [PC_W-1:0] pc_q;
	logic signed [5:0] zoom_q;
	logic [31:0] wend_q;

	logic [CHANNELS-1:0] chg_q;
	logic [TIME_BITS-1:0] time_q;
	logic last_q;
	logic [CHW-1:0] ch_q;

	logic [TIME_BITS-1:0] edge_time_q [CHANNELS];
	logic [CHANNELS-1:0] edge_seen_q;
	logic [TIME_BITS-1:0] short_q;
	logic sv_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic [TIME_BITS-1:0] delta_q;
	logic [MW-1:0] acc_q;
	logic [2:0] k_q;
	logic mok_q;

	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [31:0] quo_q;
	logic sat_q;
	logic [DIV_N_W-1:0] n_q;

	logic m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic m_tuser_q;

	ctrl_t ctl;
	logic cond_hit;
	logic [PC_W-1:0] pc_next;
	logic in_acc;
	logic out_busy;
	logic cfg_wr;

	logic [5:0] zneg;
	logic [THR_W-1:0] thr;
	logic skip_c;
	logic chan_hit;
	logic [TIME_BITS-1:0] delta_c;
	logic new_short;
	logic [MW-1:0] acc_next;
	logic found;
	logic [AW-1:0] sum_add;
	logic [CNT_W:0] cnt_add;
	logic [CNT_W:0] rem_sh;
	logic div_ge;
	logic [CNT_W-1:0] rem_nx;
	logic [31:0] step_raw;
	logic [31:0] step_c;

	assign ctl = ucode(pc_q);
	assign s_tready = (pc_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_busy = m_tvalid_q && !m_tready;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_ZOOM: prdata = {{26{zoom_q[5]}}, zoom_q};
			REG_WEND: prdata = wend_q;
			default: prdata = '0;
		endcase
	end

	assign zneg = 6'(~zoom_q + 6'sd1);
	assign thr = zoom_q[5] ? (THR_W'(5) << zneg) : (THR_W'(5) >> $unsigned(zoom_q));
	assign skip_c = (time_q >= TIME_BITS'(wend_q)) ||
		(sv_q && (CW'(short_q) <= CW'(thr)));

	assign chan_hit = chg_q[ch_q];
	assign delta_c = time_q - edge_time_q[ch_q];
	assign new_short = !sv_q || (short_q > delta_q);
	assign acc_next = acc_q + MW'(short_q);
	assign found = MW'(delta_q) < acc_next;
	assign sum_add = AW'(sum_q) + AW'(delta_q);
	assign cnt_add = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(k_q);

	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign div_ge = rem_sh >= {1'b0, cnt_q};
	assign rem_nx = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];

	assign step_raw = sat_q ? 32'hFFFF_FFFF : quo_q;
	assign step_c = (!sv_q || (cnt_q == '0) || (step_raw < STEP_MIN)) ? '0 : step_raw;

	always_comb begin
		case (ctl.cond)
			C_NEVER: cond_hit = 1'b0;
			C_NO_IN: cond_hit = !in_acc;
			C_SKIP: cond_hit = skip_c;
			C_NO_DELTA: cond_hit = !(chan_hit && edge_seen_q[ch_q]);
			C_NOT_MULT: cond_hit = new_short || (short_q == '0);
			C_MUL_MORE: cond_hit = !found && (k_q != MULT_LIMIT);
			C_MORE_CH: cond_hit = (ch_q != CH_LAST);
			C_NOT_LAST: cond_hit = !last_q;
			C_DIV_MORE: cond_hit = (n_q != DIV_N_W'(1));
			C_OUT_BUSY: cond_hit = out_busy;
			default: cond_hit = 1'b0;
		endcase
		if (cond_hit) begin
			pc_next = ctl.target;
		end else if (pc_q == S_LAST) begin
			pc_next = S_IDLE;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
			zoom_q <= '0;
			wend_q <= WEND_RESET;
			edge_seen_q <= '0;
			short_q <= '0;
			sv_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (cfg_wr) begin
				case (paddr[2])
					REG_ZOOM: zoom_q <= pwdata[5:0];
					REG_WEND: wend_q <= pwdata;
					default: ;
				endcase
			end
			if ((ctl.op == OP_OUT) && !out_busy) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (ctl.op)
				OP_EDGE: begin
					if (chan_hit) begin
						edge_seen_q[ch_q] <= 1'b1;
					end
				end
				OP_CMP: begin
					if (new_short) begin
						short_q <= delta_q;
						sv_q <= 1'b1;
						sum_q <= (AW'(delta_q) > AW'(SUM_MAX)) ? SUM_MAX : SUM_W'(delta_q);
						cnt_q <= CNT_W'(1);
					end
				end
				OP_ACC: begin
					if (mok_q) begin
						sum_q <= (sum_add > AW'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_add);
						cnt_q <= cnt_add[CNT_W] ? CNT_MAX : cnt_add[CNT_W-1:0];
					end
				end
				OP_OUT: begin
					if (!out_busy) begin
						edge_seen_q <= '0;
						short_q <= '0;
						sv_q <= 1'b0;
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				OP_NONE, OP_LOAD, OP_SKIP, OP_MUL, OP_NEXT, OP_DIVI, OP_DIV: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (in_acc) begin
					chg_q <= s_tdata[CHANNELS-1:0] ^ s_tdata[2*CHANNELS-1:CHANNELS];
					time_q <= TIME_BITS'(s_tdata[2*CHANNELS +: WB]);
					last_q <= s_tlast;
				end
			end
			OP_SKIP: ch_q <= '0;
			OP_EDGE: begin
				if (chan_hit) begin
					edge_time_q[ch_q] <= time_q;
				end
				delta_q <= delta_c;
			end
			OP_CMP: begin
				acc_q <= MW'(short_q);
				k_q <= 3'd1;
				mok_q <= 1'b0;
			end
			OP_MUL: begin
				if (found) begin
					mok_q <= 1'b1;
				end else if (k_q != MULT_LIMIT) begin
					k_q <= k_q + 3'd1;
					acc_q <= acc_next;
				end
			end
			OP_NEXT: begin
				if (ch_q != CH_LAST) begin
					ch_q <= ch_q + 1'b1;
				end
			end
			OP_DIVI: begin
				dvd_q <= sum_q;
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				n_q <= DIV_BASE + {zoom_q[5], zoom_q};
			end
			OP_DIV: begin
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= {quo_q[30:0], div_ge};
				sat_q <= sat_q | quo_q[31];
				n_q <= n_q - 1'b1;
			end
			OP_OUT: begin
				if (!out_busy) begin
					m_tdata_q <= step_c;
					m_tuser_q <= sv_q;
				end
			end
			OP_NONE, OP_ACC: ;
			default: ;
		endcase
	end

	`SEIE_ASSERT_NOW(a_out_from_seq, $rose(m_tvalid_q), $past(pc_q) == S_OUT,
		"output word raised outside the output step")
	`SEIE_ASSERT_NOW(a_step_needs_interval, m_tvalid_q && (m_tdata_q != '0), m_tuser_q,
		"nonzero grid step without a measured interval")
	`SEIE_ASSERT_NOW(a_count_tracks_valid, 1'b1, sv_q == (cnt_q != '0),
		"weighted count disagrees with shortest valid")
	`SEIE_ASSERT_NEXT(a_div_exit, pc_q == S_DIV, (pc_q == S_DIV) || (pc_q == S_OUT),
		"divider left to an unexpected step")

endmodule

`default_nettype wire
